// ----- design/ialm_pkg.sv -----
// ----------------------------------------------------------------------------
// ialm_pkg
// shared types and constants of the interleaved audio level meter
// ----------------------------------------------------------------------------
package ialm_pkg;

    localparam int CHANNELS_DEFAULT = 6;
    localparam int SAMPLE_W         = 24;
    localparam int PEAK_W           = 24;
    localparam int SQUARE_W         = 2 * SAMPLE_W;
    localparam int ENERGY_W         = 64;
    localparam int COUNT_W          = 48;
    localparam int CHAN_W           = 3;

    localparam logic [COUNT_W-1:0]  COUNT_MAX  = {COUNT_W{1'b1}};
    localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef enum logic
    {
        CMD_COMMIT = 1'b0,
        CMD_REPORT = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        B_IDLE   = 2'd0,
        B_SQUARE = 2'd1,
        B_ACCUM  = 2'd2,
        B_REPORT = 2'd3
    } back_state_t;

    typedef struct packed
    {
        logic push;
        cmd_t cmd;
    } q_wr_t;

    typedef struct packed
    {
        logic valid;
        cmd_t cmd;
    } q_rd_t;

endpackage

// ----- design/ialm_front.sv -----
// ----------------------------------------------------------------------------
// ialm_front
// byte framing, sample assembly and frame buffer; issues commit and report
// commands into the command queue
// ----------------------------------------------------------------------------
module ialm_front
    import ialm_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEFAULT
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  logic                         kind,
    input  logic [7:0]                   data_byte,
    input  logic                         packet_end,
    output q_wr_t                        q_wr,
    output logic [CHANNELS*SAMPLE_W-1:0] q_samples,
    input  logic                         q_full
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);
    localparam logic [1:0] LANE_LOW  = 2'd0;
    localparam logic [1:0] LANE_MID  = 2'd1;
    localparam logic [1:0] LANE_HIGH = 2'd2;

    logic [1:0]          lane_reg, lane_next;
    logic [CH_W-1:0]     ch_reg, ch_next;
    logic [15:0]         hold_reg, hold_next;
    logic [SAMPLE_W-1:0] samples_reg [CHANNELS];

    logic                accept;
    logic                is_data;
    logic [SAMPLE_W-1:0] new_sample;

    assign req_stall  = q_full;
    assign accept     = req_valid && !q_full;
    assign is_data    = (kind == KIND_DATA);
    assign new_sample = {data_byte, hold_reg};

    always_comb
    begin
        q_wr.push = 1'b0;
        q_wr.cmd  = CMD_COMMIT;
        if (accept)
        begin
            if (!is_data)
            begin
                q_wr.push = 1'b1;
                q_wr.cmd  = CMD_REPORT;
            end
            else if (lane_reg == LANE_HIGH && ch_reg == LAST_CH)
            begin
                q_wr.push = 1'b1;
            end
        end
    end

    // the last sample of a frame goes straight to the queue
    always_comb
    begin
        for (int c = 0; c < CHANNELS - 1; c++)
        begin
            q_samples[c*SAMPLE_W +: SAMPLE_W] = samples_reg[c];
        end
        q_samples[(CHANNELS-1)*SAMPLE_W +: SAMPLE_W] = new_sample;
    end

    always_comb
    begin
        lane_next = lane_reg;
        ch_next   = ch_reg;
        hold_next = hold_reg;
        if (accept && is_data)
        begin
            case (lane_reg)
                LANE_LOW:
                begin
                    hold_next = {8'h00, data_byte};
                    lane_next = LANE_MID;
                end
                LANE_MID:
                begin
                    hold_next = {data_byte, hold_reg[7:0]};
                    lane_next = LANE_HIGH;
                end
                default:
                begin
                    lane_next = LANE_LOW;
                    ch_next   = (ch_reg == LAST_CH) ? '0 : ch_reg + 1'b1;
                end
            endcase
            if (packet_end)
            begin
                lane_next = LANE_LOW;
                ch_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_reg <= LANE_LOW;
            ch_reg   <= '0;
            hold_reg <= '0;
        end
        else
        begin
            lane_reg <= lane_next;
            ch_reg   <= ch_next;
            hold_reg <= hold_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && is_data && lane_reg == LANE_HIGH)
        begin
            samples_reg[ch_reg] <= new_sample;
        end
    end

endmodule

// ----- design/ialm_queue.sv -----
// ----------------------------------------------------------------------------
// ialm_queue
// two-entry command queue between framing front and statistics back
// ----------------------------------------------------------------------------
module ialm_queue
    import ialm_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEFAULT
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  q_wr_t                        q_wr,
    input  logic [CHANNELS*SAMPLE_W-1:0] wr_samples,
    output logic                         q_full,
    output q_rd_t                        q_rd,
    output logic [CHANNELS*SAMPLE_W-1:0] rd_samples,
    input  logic                         q_pop
);

    localparam int DATA_W = CHANNELS * SAMPLE_W;

    cmd_t              cmd_mem  [2];
    logic [DATA_W-1:0] data_mem [2];
    logic              wr_ptr_reg, rd_ptr_reg;
    logic [1:0]        count_reg;
    logic              do_push, do_pop;

    assign q_full     = (count_reg == 2'd2);
    assign q_rd.valid = (count_reg != 2'd0);
    assign q_rd.cmd   = cmd_mem[rd_ptr_reg];
    assign rd_samples = data_mem[rd_ptr_reg];
    assign do_push    = q_wr.push && !q_full;
    assign do_pop     = q_pop && q_rd.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            cmd_mem[wr_ptr_reg]  <= q_wr.cmd;
            data_mem[wr_ptr_reg] <= wr_samples;
        end
    end

endmodule

// ----- design/ialm_back.sv -----
// ----------------------------------------------------------------------------
// ialm_back
// per-channel peak and saturating energy update, frame count, report output
// ----------------------------------------------------------------------------
module ialm_back
    import ialm_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEFAULT
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  q_rd_t                        q_rd,
    input  logic [CHANNELS*SAMPLE_W-1:0] rd_samples,
    output logic                         q_pop,
    output logic                         res_valid,
    input  logic                         res_stall,
    output logic [CHAN_W-1:0]            channel,
    output logic [PEAK_W-1:0]            peak_level,
    output logic [ENERGY_W-1:0]          energy_sum,
    output logic [COUNT_W-1:0]           frame_count,
    output logic                         last
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

    back_state_t         state_reg, state_next;
    logic [CH_W-1:0]     idx_reg, idx_next;
    logic [PEAK_W-1:0]   mag_reg;
    logic [SQUARE_W-1:0] sq_reg;
    logic [PEAK_W-1:0]   peak_reg   [CHANNELS];
    logic [ENERGY_W-1:0] energy_reg [CHANNELS];
    logic [COUNT_W-1:0]  total_reg;

    logic                out_valid_reg;
    logic [CHAN_W-1:0]   out_chan_reg;
    logic [PEAK_W-1:0]   out_peak_reg;
    logic [ENERGY_W-1:0] out_energy_reg;
    logic [COUNT_W-1:0]  out_count_reg;
    logic                out_last_reg;

    logic [SAMPLE_W-1:0] sample;
    logic [PEAK_W-1:0]   mag;
    logic [ENERGY_W:0]   energy_add;
    logic [ENERGY_W-1:0] energy_new;
    logic                out_free;
    logic                load_out;
    logic                do_accum;
    logic                frame_done;

    assign sample     = rd_samples[idx_reg*SAMPLE_W +: SAMPLE_W];
    assign mag        = sample[SAMPLE_W-1] ? (~sample + 1'b1) : sample;
    assign energy_add = {1'b0, energy_reg[idx_reg]} + {{(ENERGY_W-SQUARE_W+1){1'b0}}, sq_reg};
    assign energy_new = energy_add[ENERGY_W] ? ENERGY_MAX : energy_add[ENERGY_W-1:0];
    assign out_free   = !out_valid_reg || !res_stall;

    assign res_valid   = out_valid_reg;
    assign channel     = out_chan_reg;
    assign peak_level  = out_peak_reg;
    assign energy_sum  = out_energy_reg;
    assign frame_count = out_count_reg;
    assign last        = out_last_reg;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        q_pop      = 1'b0;
        load_out   = 1'b0;
        do_accum   = 1'b0;
        frame_done = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                idx_next = '0;
                if (q_rd.valid)
                begin
                    state_next = (q_rd.cmd == CMD_REPORT) ? B_REPORT : B_SQUARE;
                end
            end
            B_SQUARE:
            begin
                state_next = B_ACCUM;
            end
            B_ACCUM:
            begin
                do_accum = 1'b1;
                if (idx_reg == LAST_CH)
                begin
                    frame_done = 1'b1;
                    q_pop      = 1'b1;
                    state_next = B_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = B_SQUARE;
                end
            end
            B_REPORT:
            begin
                if (out_free)
                begin
                    load_out = 1'b1;
                    if (idx_reg == LAST_CH)
                    begin
                        q_pop      = 1'b1;
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            idx_reg       <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                peak_reg[c]   <= '0;
                energy_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (do_accum)
            begin
                if (mag_reg > peak_reg[idx_reg])
                begin
                    peak_reg[idx_reg] <= mag_reg;
                end
                energy_reg[idx_reg] <= energy_new;
            end
            if (frame_done && total_reg != COUNT_MAX)
            begin
                total_reg <= total_reg + 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == B_SQUARE)
        begin
            mag_reg <= mag;
            sq_reg  <= SQUARE_W'(mag) * SQUARE_W'(mag);
        end
        if (load_out)
        begin
            out_chan_reg   <= CHAN_W'(idx_reg);
            out_peak_reg   <= peak_reg[idx_reg];
            out_energy_reg <= energy_reg[idx_reg];
            out_count_reg  <= total_reg;
            out_last_reg   <= (idx_reg == LAST_CH);
        end
    end

endmodule

// ----- design/interleaved_audio_level_meter.sv -----
// ----------------------------------------------------------------------------
// interleaved_audio_level_meter
// per-channel peak and energy meter over interleaved 24-bit audio frames
// report: a request passes through the queue and the back end's report state into the
//   output register; results follow one per cycle unless stalled, CHANNELS in all
// throughput: one byte per cycle unless the queue is full; a frame commit holds the
//   back end for its idle state, then square and accumulate per channel; 2-entry queue
// reset: asynchronous, clears framing, peaks, energies, frame count and queue
// ----------------------------------------------------------------------------
module interleaved_audio_level_meter
    import ialm_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  logic                kind,
    input  logic [7:0]          data_byte,
    input  logic                packet_end,
    output logic                res_valid,
    input  logic                res_stall,
    output logic [CHAN_W-1:0]   channel,
    output logic [PEAK_W-1:0]   peak_level,
    output logic [ENERGY_W-1:0] energy_sum,
    output logic [COUNT_W-1:0]  frame_count,
    output logic                last
);

    q_wr_t                        q_wr;
    q_rd_t                        q_rd;
    logic                         q_full;
    logic                         q_pop;
    logic [CHANNELS*SAMPLE_W-1:0] wr_samples;
    logic [CHANNELS*SAMPLE_W-1:0] rd_samples;

    ialm_front #(.CHANNELS(CHANNELS)) u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .kind       (kind),
        .data_byte  (data_byte),
        .packet_end (packet_end),
        .q_wr       (q_wr),
        .q_samples  (wr_samples),
        .q_full     (q_full)
    );

    ialm_queue #(.CHANNELS(CHANNELS)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_wr       (q_wr),
        .wr_samples (wr_samples),
        .q_full     (q_full),
        .q_rd       (q_rd),
        .rd_samples (rd_samples),
        .q_pop      (q_pop)
    );

    ialm_back #(.CHANNELS(CHANNELS)) u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_rd        (q_rd),
        .rd_samples  (rd_samples),
        .q_pop       (q_pop),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .channel     (channel),
        .peak_level  (peak_level),
        .energy_sum  (energy_sum),
        .frame_count (frame_count),
        .last        (last)
    );

endmodule

// ----- sim/interleaved_audio_level_meter_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// interleaved_audio_level_meter_test
// drives packet bytes and report requests into the level meter, tracks
// framing, peaks, energies and frame count alongside it, and checks every
// reported channel against that running copy; the sender bursts and the
// receiver stalls, once for a long stretch so the request side backs up
// ----------------------------------------------------------------------------
module interleaved_audio_level_meter_test;
    import ialm_pkg::*;

    localparam int NCH        = CHANNELS_DEFAULT;
    localparam int FRAME_LEN  = 3 * NCH;
    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_LEN   = 250;

    typedef struct {
        logic       kind;
        logic [7:0] data_byte;
        logic       packet_end;
    } meter_req_t;

    typedef struct {
        logic [CHAN_W-1:0]   channel;
        logic [PEAK_W-1:0]   peak_level;
        logic [ENERGY_W-1:0] energy_sum;
        logic [COUNT_W-1:0]  frame_count;
        logic                last;
    } level_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_stall;
    logic                kind = KIND_DATA;
    logic [7:0]          data_byte = 8'd0;
    logic                packet_end = 1'b0;
    logic                res_valid;
    logic                res_stall = 1'b0;
    logic [CHAN_W-1:0]   channel;
    logic [PEAK_W-1:0]   peak_level;
    logic [ENERGY_W-1:0] energy_sum;
    logic [COUNT_W-1:0]  frame_count;
    logic                last;

    meter_req_t pending_requests[$];
    level_t     expected_levels[$];

    // running copy of the meter
    int unsigned         frame_pos;
    logic [15:0]         byte_hold;
    logic [23:0]         frame_buf[NCH];
    logic [PEAK_W-1:0]   peak_seen[NCH];
    logic [ENERGY_W-1:0] energy_acc[NCH];
    logic [COUNT_W-1:0]  frames_done;

    int          errors = 0;
    int          req_count = 0;
    int          idle_cycles = 0;
    logic        req_fire = 1'b0;
    int          planned_items = 0;
    int          planned_levels = 0;
    int          burst_left = 1;
    int          gap_left = 0;
    int          rx_mode = 0;
    int          rx_left = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    meter_req_t  next_req;
    level_t      got;
    level_t      want;
    logic        offer;

    interleaved_audio_level_meter u_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .kind        (kind),
        .data_byte   (data_byte),
        .packet_end  (packet_end),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .channel     (channel),
        .peak_level  (peak_level),
        .energy_sum  (energy_sum),
        .frame_count (frame_count),
        .last        (last)
    );

    always #6 clk = ~clk;

    function automatic void reset_meter();
        frame_pos   = 0;
        byte_hold   = '0;
        frames_done = '0;
        for (int c = 0; c < NCH; c++)
        begin
            frame_buf[c]  = '0;
            peak_seen[c]  = '0;
            energy_acc[c] = '0;
        end
    endfunction

    function automatic void update_meter(input meter_req_t r);
        level_t      lv;
        logic [23:0] mag;
        logic [63:0] sq;
        int unsigned lane;
        int unsigned ch;
        if (r.kind == KIND_REPORT)
        begin
            for (int c = 0; c < NCH; c++)
            begin
                lv.channel     = c[CHAN_W-1:0];
                lv.peak_level  = peak_seen[c];
                lv.energy_sum  = energy_acc[c];
                lv.frame_count = frames_done;
                lv.last        = (c == NCH - 1);
                expected_levels.push_back(lv);
            end
            return;
        end
        lane = frame_pos % 3;
        ch   = frame_pos / 3;
        if (lane == 0)
            byte_hold = {8'd0, r.data_byte};
        else if (lane == 1)
            byte_hold = {r.data_byte, byte_hold[7:0]};
        else if (ch < NCH)
            frame_buf[ch] = {r.data_byte, byte_hold};
        frame_pos++;
        if (frame_pos >= FRAME_LEN)
        begin
            for (int c = 0; c < NCH; c++)
            begin
                mag = frame_buf[c][23] ? (~frame_buf[c] + 24'd1) : frame_buf[c];
                sq  = 64'(mag) * 64'(mag);
                if (mag > peak_seen[c])
                    peak_seen[c] = mag;
                if (energy_acc[c] > ENERGY_MAX - sq)
                    energy_acc[c] = ENERGY_MAX;
                else
                    energy_acc[c] = energy_acc[c] + sq;
            end
            if (frames_done < COUNT_MAX)
                frames_done = frames_done + 1'b1;
            frame_pos = 0;
        end
        if (r.packet_end)
            frame_pos = 0;
    endfunction

    task automatic add_byte(input logic [7:0] b, input logic pe);
        meter_req_t r;
        r.kind       = KIND_DATA;
        r.data_byte  = b;
        r.packet_end = pe;
        pending_requests.push_back(r);
        planned_items++;
    endtask

    task automatic add_report();
        meter_req_t r;
        r.kind       = KIND_REPORT;
        r.data_byte  = 8'($urandom);
        r.packet_end = 1'($urandom);
        pending_requests.push_back(r);
        planned_items++;
        planned_levels += NCH;
    endtask

    function automatic logic [23:0] pick_sample();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return 24'h800000;
        else if (sel == 1)
            return 24'h7FFFFF;
        else if (sel == 2)
            return 24'hFFFFFF;
        return 24'($urandom);
    endfunction

    // stimulus
    initial
    begin
        logic [23:0] s;
        logic [23:0] directed[NCH];
        int          sel;
        int          nframes;
        int          mid;
        int          idx;
        int          n;
        directed = '{24'h800000, 24'h7FFFFF, 24'h000000, 24'hFFFFFF, 24'h000001, 24'h800001};
        // report before any frame
        add_report();
        // extreme samples, frame completed by the packet-end byte
        for (int c = 0; c < NCH; c++)
            for (int l = 0; l < 3; l++)
                add_byte(directed[c][8*l +: 8], (c == NCH - 1) && (l == 2));
        add_report();
        // partial frame dropped at packet end
        add_byte(8'hFF, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h7F, 1'b0);
        add_byte(8'h00, 1'b1);
        add_report();

        while (planned_items < 190 || planned_levels < 72)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 65)
            begin
                nframes = $urandom_range(1, 2);
                mid = -1;
                if ($urandom_range(0, 3) == 0)
                    mid = $urandom_range(0, nframes * FRAME_LEN - 1);
                idx = 0;
                for (int f = 0; f < nframes; f++)
                    for (int c = 0; c < NCH; c++)
                    begin
                        s = pick_sample();
                        for (int l = 0; l < 3; l++)
                        begin
                            if (idx == mid)
                                add_report();
                            add_byte(s[8*l +: 8], (f == nframes - 1) && (c == NCH - 1) && (l == 2));
                            idx++;
                        end
                    end
            end
            else if (sel < 80)
            begin
                n = $urandom_range(0, 1) * FRAME_LEN + $urandom_range(1, FRAME_LEN - 1);
                for (int i = 0; i < n; i++)
                    add_byte(8'($urandom), i == n - 1);
            end
            else if (sel < 88)
            begin
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++)
                    add_byte(8'($urandom), $urandom_range(0, 3) == 0);
            end
            else
                add_report();
            if ($urandom_range(0, 2) == 0)
                add_report();
        end

        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        do
            @(posedge clk);
        while (pending_requests.size() != 0 || req_valid);
        while (expected_levels.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        errors += expected_levels.size();
        if (errors == 0)
            $display("interleaved_audio_level_meter_test: clean");
        else
            $display("interleaved_audio_level_meter_test: errors");
        $finish;
    end

    // request driver
    always @(negedge clk)
    begin
        if (rst_n && !(req_valid && !req_fire))
        begin
            offer = 1'b0;
            if (gap_left > 0)
                gap_left--;
            else if (pending_requests.size() > 0)
            begin
                next_req = pending_requests.pop_front();
                offer = 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                    burst_left--;
            end
            req_valid <= offer;
            if (offer)
            begin
                kind       <= next_req.kind;
                data_byte  <= next_req.data_byte;
                packet_end <= next_req.packet_end;
            end
        end
    end

    // result stall pattern, with one long hold
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                res_stall <= 1'b1;
            end
            else if (!hold_done && req_count >= 60)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN - 1;
                res_stall <= 1'b1;
            end
            else
            begin
                if (rx_left == 0)
                begin
                    rx_mode = $urandom_range(0, 2);
                    rx_left = $urandom_range(10, 60);
                end
                rx_left--;
                case (rx_mode)
                    0:       res_stall <= 1'b0;
                    1:       res_stall <= ($urandom_range(0, 1) == 0);
                    default: res_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // request tracking and result checking
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            reset_meter();
            req_fire <= 1'b0;
        end
        else
        begin
            req_fire <= req_valid && !req_stall;
            if (req_valid && !req_stall)
            begin
                next_req.kind       = kind;
                next_req.data_byte  = data_byte;
                next_req.packet_end = packet_end;
                update_meter(next_req);
                req_count++;
            end
            if (res_valid && !res_stall)
            begin
                got.channel     = channel;
                got.peak_level  = peak_level;
                got.energy_sum  = energy_sum;
                got.frame_count = frame_count;
                got.last        = last;
                if (expected_levels.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected result: channel %0d peak %0d energy %0d frames %0d",
                                 got.channel, got.peak_level, got.energy_sum, got.frame_count);
                    errors++;
                end
                else
                begin
                    want = expected_levels.pop_front();
                    if (got.channel !== want.channel || got.peak_level !== want.peak_level ||
                        got.energy_sum !== want.energy_sum ||
                        got.frame_count !== want.frame_count || got.last !== want.last)
                    begin
                        if (errors < 10)
                            $display({"mismatch: channel %0d/%0d peak %0d/%0d energy %0d/%0d ",
                                      "frames %0d/%0d last %0d/%0d (expected/actual)"},
                                     want.channel, got.channel, want.peak_level, got.peak_level,
                                     want.energy_sum, got.energy_sum,
                                     want.frame_count, got.frame_count, want.last, got.last);
                        errors++;
                    end
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (res_valid && !res_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("interleaved_audio_level_meter_test: errors");
                $finish;
            end
        end
    end

endmodule
